// ===== sv/baro_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the barometric compensation pipeline.
// Used by every module of the block; depends on nothing.
package baro_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TEMP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9  = 2'd3;

  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = 66;
  localparam int STG_DIV = 13;
  localparam int STG_QUO = STG_DIV + DIV_LAT;
  localparam int STG_OUT = STG_QUO + 6;

  typedef struct packed {
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
  } baro_in_t;

  typedef struct packed {
    logic signed [23:0] temperature;
    logic signed [31:0] fine_temp;
    logic [31:0]        pressure;
    logic               pressure_invalid;
  } baro_out_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// Top level of the barometric temperature and pressure compensation pipeline.
// Uses baro_pkg, baro_mul64 and baro_div64.
//
//  channel | ports                          | transfer
//  input   | start, busy, in_data           | start high and busy low at a clock edge
//  result  | out_strobe, out_data           | one cycle with out_strobe high
//  config  | cfg_we, cfg_index, cfg_wdata   | cfg_we high at a clock edge
//
// One reading enters per cycle; busy is always low.
// Each result follows its input transfer through the multiplier stages and the
// 64-stage divider.
// Reset clears the calibration registers and the valid pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module baro_temp_pressure_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  baro_pkg::baro_in_t                in_data,
  output logic                              out_strobe,
  output baro_pkg::baro_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [baro_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [baro_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
  import baro_pkg::*;

  logic [47:0] cal_temp_r;
  logic [63:0] cal_plo_r;
  logic [63:0] cal_phi_r;
  logic [15:0] cal_p9_r;
  logic        vld_r [1:STG_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r <= '0;
      cal_plo_r  <= '0;
      cal_phi_r  <= '0;
      cal_p9_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAL_TEMP: cal_temp_r <= cfg_wdata[47:0];
        CFG_PRESS_LO: cal_plo_r  <= cfg_wdata;
        CFG_PRESS_HI: cal_phi_r  <= cfg_wdata;
        CFG_PRESS_P9: cal_p9_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= STG_OUT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[1] <= start && !busy;
      for (int i = 2; i <= STG_OUT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2;
  logic signed [15:0] t3;
  assign t1 = cal_temp_r[15:0];
  assign t2 = cal_temp_r[31:16];
  assign t3 = cal_temp_r[47:32];

  logic [19:0] s1_at_r;
  logic [19:0] ap_r [1:10];

  always_ff @(posedge clk) begin
    s1_at_r  <= in_data.adc_temp;
    ap_r[1]  <= in_data.adc_press;
    for (int i = 2; i <= 10; i++) ap_r[i] <= ap_r[i-1];
  end

  logic signed [17:0] ta_nxt;
  logic signed [33:0] pa_nxt;
  logic signed [16:0] d_nxt;
  logic signed [33:0] dd_nxt;
  logic [31:0]        s2_pa_r;
  logic [31:0]        s2_dd_r;

  assign ta_nxt = $signed({1'b0, s1_at_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign pa_nxt = ta_nxt * t2;
  assign d_nxt  = $signed({1'b0, s1_at_r[19:4]}) - $signed({1'b0, t1});
  assign dd_nxt = d_nxt * d_nxt;

  always_ff @(posedge clk) begin
    s2_pa_r <= pa_nxt[31:0];
    s2_dd_r <= dd_nxt[31:0];
  end

  logic signed [19:0] ddw_nxt;
  logic signed [35:0] pb_nxt;
  logic [31:0]        s3_a_r;
  logic [31:0]        s3_pb_r;

  assign ddw_nxt = s2_dd_r[31:12];
  assign pb_nxt  = ddw_nxt * t3;

  always_ff @(posedge clk) begin
    s3_a_r  <= $unsigned($signed(s2_pa_r) >>> 11);
    s3_pb_r <= pb_nxt[31:0];
  end

  logic [31:0] fine_nxt;
  logic [31:0] s4_fine_r;

  assign fine_nxt = s3_a_r + $unsigned($signed(s3_pb_r) >>> 14);

  always_ff @(posedge clk) begin
    s4_fine_r <= fine_nxt;
  end

  logic [31:0] t5_nxt;
  logic [63:0] v1_nxt;
  logic [23:0] s5_temp_r;
  logic [31:0] s5_fine_r;
  logic [63:0] s5_v1_r;

  assign t5_nxt = s4_fine_r + {s4_fine_r[29:0], 2'b00} + 32'd128;
  assign v1_nxt = {{32{s4_fine_r[31]}}, s4_fine_r} - 64'd128000;

  always_ff @(posedge clk) begin
    s5_temp_r <= t5_nxt[31:8];
    s5_fine_r <= s4_fine_r;
    s5_v1_r   <= v1_nxt;
  end

  logic [55:0] tf_r [6:STG_OUT-1];

  always_ff @(posedge clk) begin
    tf_r[6] <= {s5_temp_r, s5_fine_r};
    for (int i = 7; i <= STG_OUT - 1; i++) tf_r[i] <= tf_r[i-1];
  end

  logic [63:0] sq7;
  logic [63:0] m5_7;
  logic [63:0] m2_7;

  baro_mul64 u_sq (.clk(clk), .a(s5_v1_r), .b(s5_v1_r), .p(sq7));
  baro_mul64 u_m5 (.clk(clk), .a(s5_v1_r), .b(sx16(cal_phi_r[15:0])), .p(m5_7));
  baro_mul64 u_m2 (.clk(clk), .a(s5_v1_r), .b(sx16(cal_plo_r[31:16])), .p(m2_7));

  logic [63:0] m6_9;
  logic [63:0] m3_9;
  logic [63:0] m5_r [8:9];
  logic [63:0] m2_r [8:9];

  baro_mul64 u_m6 (.clk(clk), .a(sq7), .b(sx16(cal_phi_r[31:16])), .p(m6_9));
  baro_mul64 u_m3 (.clk(clk), .a(sq7), .b(sx16(cal_plo_r[47:32])), .p(m3_9));

  always_ff @(posedge clk) begin
    m5_r[8] <= m5_7;
    m5_r[9] <= m5_r[8];
    m2_r[8] <= m2_7;
    m2_r[9] <= m2_r[8];
  end

  logic [63:0] v2_nxt;
  logic [63:0] x_nxt;
  logic [63:0] s10_v2_r;
  logic [63:0] s10_x_r;

  assign v2_nxt = m6_9 + (m5_r[9] << 17) + (sx16(cal_plo_r[63:48]) << 35);
  assign x_nxt  = $unsigned($signed(m3_9) >>> 8) + (m2_r[9] << 12) + (64'd1 << 47);

  always_ff @(posedge clk) begin
    s10_v2_r <= v2_nxt;
    s10_x_r  <= x_nxt;
  end

  logic [20:0] pd_nxt;
  logic [63:0] s11_n0_r;
  logic [63:0] mp1_12;
  logic [63:0] num_13;
  logic [63:0] s13_den_r;

  assign pd_nxt = 21'd1048576 - {1'b0, ap_r[10]};

  always_ff @(posedge clk) begin
    s11_n0_r <= ({43'd0, pd_nxt} << 31) - s10_v2_r;
  end

  baro_mul64 u_p1 (.clk(clk), .a(s10_x_r), .b({48'd0, cal_plo_r[15:0]}), .p(mp1_12));
  baro_mul64 u_n  (.clk(clk), .a(s11_n0_r), .b(64'd3125), .p(num_13));

  always_ff @(posedge clk) begin
    s13_den_r <= $unsigned($signed(mp1_12) >>> 33);
  end

  logic inv_r [STG_DIV+1:STG_OUT-1];

  always_ff @(posedge clk) begin
    inv_r[STG_DIV+1] <= (s13_den_r == 64'd0);
    for (int i = STG_DIV + 2; i <= STG_OUT - 1; i++) inv_r[i] <= inv_r[i-1];
  end

  logic [63:0] quo;

  baro_div64 u_div (.clk(clk), .num(num_13), .den(s13_den_r), .quo(quo));

  logic [63:0] q_nxt;
  logic [63:0] q_r  [1:2];
  logic [63:0] p_r  [1:4];
  logic [63:0] m9_2;
  logic [63:0] m8_2;
  logic [63:0] qq_4;
  logic [63:0] w2_r [3:4];

  assign q_nxt = $unsigned($signed(quo) >>> 13);

  baro_mul64 u_m9 (.clk(clk), .a(sx16(cal_p9_r)), .b(q_nxt), .p(m9_2));
  baro_mul64 u_m8 (.clk(clk), .a(sx16(cal_phi_r[63:48])), .b(quo), .p(m8_2));
  baro_mul64 u_qq (.clk(clk), .a(m9_2), .b(q_r[2]), .p(qq_4));

  always_ff @(posedge clk) begin
    q_r[1]  <= q_nxt;
    q_r[2]  <= q_r[1];
    p_r[1]  <= quo;
    for (int i = 2; i <= 4; i++) p_r[i] <= p_r[i-1];
    w2_r[3] <= $unsigned($signed(m8_2) >>> 19);
    w2_r[4] <= w2_r[3];
  end

  logic [63:0] sum_nxt;
  logic [63:0] sum_r;
  logic [63:0] pf_nxt;
  baro_out_t   out_r;

  assign sum_nxt = p_r[4] + $unsigned($signed(qq_4) >>> 25) + w2_r[4];
  assign pf_nxt  = $unsigned($signed(sum_r) >>> 8) + (sx16(cal_phi_r[47:32]) << 4);

  always_ff @(posedge clk) begin
    sum_r                  <= sum_nxt;
    out_r.temperature      <= tf_r[STG_OUT-1][55:32];
    out_r.fine_temp        <= tf_r[STG_OUT-1][31:0];
    out_r.pressure         <= inv_r[STG_OUT-1] ? 32'd0 : pf_nxt[31:0];
    out_r.pressure_invalid <= inv_r[STG_OUT-1];
  end

  assign out_strobe = vld_r[STG_OUT];
  assign out_data   = out_r;

endmodule

// ===== sv/baro_mul64.sv =====
`timescale 1ns / 1ps
// Two-stage 64 by 64 multiplier that keeps the low 64 bits of the product.
// Built from three 32 by 32 partial products; uses baro_pkg.
module baro_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  import baro_pkg::*;

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;
  logic [63:0] lh_nxt;
  logic [63:0] hl_nxt;
  logic [31:0] mid_nxt;

  assign lh_nxt  = a[31:0] * b[63:32];
  assign hl_nxt  = a[63:32] * b[31:0];
  assign mid_nxt = lh_r + hl_r;

  always_ff @(posedge clk) begin
    ll_r <= a[31:0] * b[31:0];
    lh_r <= lh_nxt[31:0];
    hl_r <= hl_nxt[31:0];
    p_r  <= ll_r + {mid_nxt, 32'd0};
  end

  assign p = p_r;

endmodule

// ===== sv/baro_div64.sv =====
`timescale 1ns / 1ps
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit per stage.
module baro_div64 (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);
  import baro_pkg::*;

  logic [63:0] ud_r  [0:64];
  logic [63:0] rem_r [0:64];
  logic [63:0] qt_r  [0:64];
  logic        neg_r [0:64];
  logic [63:0] quo_r;

  always_ff @(posedge clk) begin
    neg_r[0] <= num[63] ^ den[63];
    ud_r[0]  <= den[63] ? (64'd0 - den) : den;
    qt_r[0]  <= num[63] ? (64'd0 - num) : num;
    rem_r[0] <= '0;
  end

  genvar k;
  generate
    for (k = 0; k < 64; k++) begin : g_stg
      logic [63:0] sh_nxt;
      logic [63:0] df_nxt;
      logic        ge_nxt;
      assign sh_nxt = {rem_r[k][62:0], qt_r[k][63]};
      assign df_nxt = sh_nxt - ud_r[k];
      assign ge_nxt = (sh_nxt >= ud_r[k]);
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge_nxt ? df_nxt : sh_nxt;
        qt_r[k+1]  <= {qt_r[k][62:0], ge_nxt};
        ud_r[k+1]  <= ud_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    quo_r <= neg_r[64] ? (64'd0 - qt_r[64]) : qt_r[64];
  end

  assign quo = quo_r;

endmodule

// ===== sv/baro_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the compensation pipeline, bound to the top level.
// Uses baro_pkg for the pipeline depth and payload types.
module baro_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input baro_pkg::baro_out_t            out_data
);
  import baro_pkg::*;

  logic [31:0] t5;
  assign t5 = out_data.fine_temp + {out_data.fine_temp[29:0], 2'b00} + 32'd128;

  a_no_strobe_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_strobe_has_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, STG_OUT))
    else $error("result without a matching input transfer");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.pressure_invalid |-> out_data.pressure == 32'd0)
    else $error("invalid pressure is not zero");

  a_temp_matches_fine: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.temperature == t5[31:8])
    else $error("temperature does not follow fine temperature");

endmodule

bind baro_temp_pressure_compensation baro_chk u_baro_chk (.*);

// ===== dv/tb_baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for baro_temp_pressure_compensation: a directed table,
// then random readings under several calibration settings. Depends on baro_pkg.
module tb_baro_temp_pressure_compensation;
  import baro_pkg::*;

  localparam int LATENCY = STG_OUT;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  baro_in_t in_data = '0;
  logic out_strobe;
  baro_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  logic [47:0] cal_t_q;
  logic [63:0] cal_plo_q;
  logic [63:0] cal_phi_q;
  logic [15:0] cal_p9_q;

  baro_out_t pending_readings[$];
  int errors = 0;
  int cycles = 0;

  typedef struct {
    logic [19:0] at;
    logic [19:0] ap;
    logic        typed;
    baro_out_t   want;
  } row_t;

  baro_temp_pressure_compensation i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    logic [63:0] r;
    r = {{48{v[15]}}, v};
    return r;
  endfunction

  function automatic baro_out_t compensate(input logic [19:0] at, input logic [19:0] ap);
    logic signed [31:0] t1, t2, t3, a, d, b, fine, tmp;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, f, p, q, w1, w2, un, ud, uq;
    baro_out_t r;
    t1 = {16'h0, cal_t_q[15:0]};
    t2 = {{16{cal_t_q[31]}}, cal_t_q[31:16]};
    t3 = {{16{cal_t_q[47]}}, cal_t_q[47:32]};
    a = (({12'h0, at} >>> 3) - (t1 << 1)) * t2;
    a = a >>> 11;
    d = ({12'h0, at} >>> 4) - t1;
    b = (d * d) >>> 12;
    b = (b * t3) >>> 14;
    fine = a + b;
    tmp = (fine * 5 + 128) >>> 8;
    p1 = {48'h0, cal_plo_q[15:0]};
    p2 = sext16(cal_plo_q[31:16]);
    p3 = sext16(cal_plo_q[47:32]);
    p4 = sext16(cal_plo_q[63:48]);
    p5 = sext16(cal_phi_q[15:0]);
    p6 = sext16(cal_phi_q[31:16]);
    p7 = sext16(cal_phi_q[47:32]);
    p8 = sext16(cal_phi_q[63:48]);
    p9 = sext16(cal_p9_q);
    f = fine;
    v1 = f - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
    v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
    r.temperature = tmp[23:0];
    r.fine_temp = fine;
    r.pressure = '0;
    r.pressure_invalid = 1'b0;
    if (v1 == 0) begin
      r.pressure_invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - {44'h0, ap};
      p = ((p << 31) - v2) * 64'sd3125;
      un = p[63] ? -p : p;
      ud = v1[63] ? -v1 : v1;
      uq = $unsigned(un) / $unsigned(ud);
      p = (p[63] != v1[63]) ? -uq : uq;
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 << 4);
      r.pressure = p[31:0];
    end
    return r;
  endfunction

  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CAL_TEMP: cal_t_q = val[47:0];
      CFG_PRESS_LO: cal_plo_q = val;
      CFG_PRESS_HI: cal_phi_q = val;
      default: cal_p9_q = val[15:0];
    endcase
  endtask

  task automatic load_cal(input logic [47:0] t, input logic [63:0] lo, input logic [63:0] hi,
                          input logic [15:0] p9);
    write_cal(CFG_CAL_TEMP, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | t);
    write_cal(CFG_PRESS_LO, lo);
    write_cal(CFG_PRESS_HI, hi);
    write_cal(CFG_PRESS_P9, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | p9);
    cfg_we <= 1'b0;
  endtask

  task automatic send_reading(input logic [19:0] at, input logic [19:0] ap, input bit quiet,
                              input bit typed, input baro_out_t want);
    while (!quiet && $urandom_range(99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{adc_temp: at, adc_press: ap};
    pending_readings.push_back(typed ? want : compensate(at, ap));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [19:0] at, ap;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: at = 20'hFFFFF;
        1: at = 20'($urandom_range(20'hFFFFF));
        default: at = 20'($urandom_range(560000, 470000));
      endcase
      ap = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 20'h0 : 20'hFFFFF)
                                    : 20'($urandom_range(20'hFFFFF));
      send_reading(at, ap, (i >= count / 3) && (i < 2 * count / 3), 1'b0, '0);
    end
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        errors <= errors + 1;
        $display("%0t unexpected transfer: actual %h", $time, out_data);
      end else begin
        if (out_data !== pending_readings[0]) begin
          errors <= errors + 1;
          $display("%0t mismatch: expected %h actual %h", $time, pending_readings[0],
                   out_data);
        end
        void'(pending_readings.pop_front());
      end
    end
  end

  initial begin
    row_t rows[$];
    baro_out_t zero_out;
    zero_out = '0;
    zero_out.pressure_invalid = 1'b1;
    cal_t_q = '0;
    cal_plo_q = '0;
    cal_phi_q = '0;
    cal_p9_q = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset every coefficient is zero, so the divisor is zero as well.
    rows.push_back('{20'h0, 20'h0, 1'b1, zero_out});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zero_out});
    rows.push_back('{20'hFFFFF, 20'h0, 1'b1, zero_out});
    foreach (rows[i]) send_reading(rows[i].at, rows[i].ap, 1'b0, rows[i].typed, rows[i].want);
    drain();

    load_cal({16'hFC18, 16'h6A56, 16'h6E6F}, {16'hC7E4, 16'hD0B4, 16'hD5D6, 16'h8E3A},
             {16'h0CF6, 16'hFFF8, 16'h003C, 16'hFFF9}, 16'd6000);
    rows.delete();
    rows.push_back('{20'd519888, 20'd415148, 1'b0, '0});
    rows.push_back('{20'h0, 20'h0, 1'b0, '0});
    rows.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, '0});
    rows.push_back('{20'h80000, 20'h7FFFF, 1'b0, '0});
    rows.push_back('{20'h00001, 20'hFFFFE, 1'b0, '0});
    foreach (rows[i]) send_reading(rows[i].at, rows[i].ap, 1'b0, 1'b0, '0);
    random_phase(250);

    // Extreme coefficients drive wrapping on both paths.
    load_cal({16'h8000, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
             {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    random_phase(150);
    load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0000},
             {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF);
    random_phase(150);

    // P1 zero forces the zero-divisor case with live temperatures.
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom} & ~64'hFFFF,
             {$urandom, $urandom}, 16'($urandom));
    random_phase(50);
    load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
             16'($urandom));
    random_phase(200);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== baro_temp_pressure_compensation.f =====
sv/baro_pkg.sv
sv/baro_mul64.sv
sv/baro_div64.sv
sv/baro_temp_pressure_compensation.sv
sv/baro_chk.sv
dv/tb_baro_temp_pressure_compensation.sv
